### hdl/lssjr_pkg.sv
// Shared types, constants and register codes of the loader shot sequencer.
package lssjr_pkg;

    localparam int SHOT_QUEUE_MAX = 255;
    localparam logic signed [31:0] RECOVERY_REF = -32'sd230400;

    typedef enum logic [2:0] {
        MODE_STOP  = 3'd0,
        MODE_SINGLE = 3'd1,
        MODE_BURST = 3'd2,
        MODE_CONT  = 3'd3,
        MODE_REV   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_STEP_ANGLE   = 3'd0,
        REG_CONT_RPM     = 3'd1,
        REG_REV_RPM      = 3'd2,
        REG_JAM_MS       = 3'd3,
        REG_RECOVERY_MS  = 3'd4,
        REG_ANGLE_TOL    = 3'd5,
        REG_SETTLE_TOL   = 3'd6,
        REG_STALL_TOL    = 3'd7
    } t_reg;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               wheels_on;
        logic               fire_gate;
        logic [2:0]         mode_req;
        logic [15:0]        request_seq;
        logic [7:0]         shots_per_burst;
        logic [15:0]        rate_hz;
        logic               feedback_ok;
        logic signed [31:0] loader_angle;
        logic signed [15:0] loader_speed;
    } t_in;

    typedef struct packed {
        logic               drive_on;
        logic               angle_loop;
        logic signed [31:0] reference;
        logic               jammed;
        logic [2:0]         shown_mode;
        logic               loader_busy;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

endpackage

### hdl/lssjr_div.sv
// Restoring serial divider, one quotient bit per cycle.
module lssjr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [18:0] i_num,
    input  logic [15:0] i_den,
    output logic [18:0] o_quot,
    output logic        o_done
);
    logic [18:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [16:0] w_try;

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        w_try = {r_rem[15:0], r_q[18]};
        if (i_start) begin
            n_q = i_num;
            n_rem = '0;
            n_cnt = 5'd19;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_try >= {1'b0, i_den}) begin
                n_rem = w_try - {1'b0, i_den};
                n_q = {r_q[17:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_q = {r_q[17:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_rem <= n_rem;
    end

    assign o_quot = r_q;
    assign o_done = !r_busy && !i_start;
endmodule

### hdl/lssjr_ctrl.sv
// Controller state machine that sequences one tick through the datapath.
module lssjr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lssjr_pkg::t_cmd      o_cmd,
    input  lssjr_pkg::t_stat     i_stat
);
    import lssjr_pkg::*;

    t_state r_state, n_state;
    logic   r_started, n_started;

    always_comb begin
        n_state = r_state;
        n_started = r_started;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) begin
                n_state = ST_DIV;
                n_started = 1'b0;
            end
            ST_DIV: begin
                n_started = 1'b1;
                if (r_started && i_stat.div_done) n_state = ST_UPDATE;
            end
            ST_UPDATE: n_state = ST_OUT;
            ST_OUT: if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DIV: o_cmd.div_start = !r_started;
            ST_UPDATE: o_cmd.update = 1'b1;
            ST_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state <= n_state;
            r_started <= n_started;
        end
    end
endmodule

### hdl/lssjr_dp.sv
// Datapath: configuration, sequencer state and the per-tick update.
module lssjr_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  lssjr_pkg::t_in       i_in,
    input  lssjr_pkg::t_cmd      i_cmd,
    output lssjr_pkg::t_stat     o_stat,
    output lssjr_pkg::t_out      o_out
);
    import lssjr_pkg::*;

    logic [14:0]        r_step_angle;
    logic signed [15:0] r_cont_rpm, r_rev_rpm;
    logic [15:0]        r_jam_ms, r_rec_ms;
    logic [11:0]        r_angle_tol, r_settle_tol, r_stall_tol;

    logic [15:0]        r_last_seq, n_last_seq;
    logic [7:0]         r_pending, n_pending;
    logic               r_step_active, n_step_active;
    logic signed [31:0] r_target, n_target;
    logic [31:0]        r_next_ms, n_next_ms;
    logic               r_recovering, n_recovering;
    logic [31:0]        r_stall_ms, n_stall_ms;
    logic               r_stall_valid, n_stall_valid;
    logic [31:0]        r_rec_end, n_rec_end;

    t_in  r_in;
    t_out r_out, n_out;

    logic [18:0] w_quot;
    logic        w_div_done;

    lssjr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (19'd256000 + {3'b000, r_in.rate_hz} - 19'd1),
        .i_den   (r_in.rate_hz),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );
    assign o_stat.div_done = w_div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_angle <= 15'd2880;
            r_cont_rpm <= 16'sd2000;
            r_rev_rpm <= -16'sd1000;
            r_jam_ms <= 16'd120;
            r_rec_ms <= 16'd120;
            r_angle_tol <= 12'd128;
            r_settle_tol <= 12'd180;
            r_stall_tol <= 12'd60;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_STEP_ANGLE:  r_step_angle <= i_cfg_data[14:0];
                REG_CONT_RPM:    r_cont_rpm <= i_cfg_data;
                REG_REV_RPM:     r_rev_rpm <= i_cfg_data;
                REG_JAM_MS:      r_jam_ms <= i_cfg_data;
                REG_RECOVERY_MS: r_rec_ms <= i_cfg_data;
                REG_ANGLE_TOL:   r_angle_tol <= i_cfg_data[11:0];
                REG_SETTLE_TOL:  r_settle_tol <= i_cfg_data[11:0];
                REG_STALL_TOL:   r_stall_tol <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic [2:0]         w_mode;
    logic               w_single;
    logic [16:0]        w_abs_speed;
    logic               w_at_old;
    logic               w_at;
    logic               w_slow;
    logic [8:0]         w_q;
    logic [7:0]         w_cnt;
    logic signed [32:0] w_t;
    logic [31:0]        w_dead;
    logic               w_drive, w_aloop;
    logic signed [31:0] w_ref;

    // At-target test: absolute angle error and loader speed within their tolerances, with feedback online.
    function automatic logic at_tgt(input logic signed [31:0] tg, input logic signed [31:0] ang,
                                    input logic [16:0] aspd, input logic [11:0] atol,
                                    input logic [11:0] stol, input logic online);
        logic signed [32:0] d;
        logic [32:0] ad;
        d = {tg[31], tg} - {ang[31], ang};
        ad = d[32] ? 33'(-d) : 33'(d);
        return online && (ad <= {21'd0, atol}) && (aspd <= {5'd0, stol});
    endfunction

    always_comb begin
        n_last_seq = r_last_seq;
        n_pending = r_pending;
        n_step_active = r_step_active;
        n_target = r_target;
        n_next_ms = r_next_ms;
        n_recovering = r_recovering;
        n_stall_ms = r_stall_ms;
        n_stall_valid = r_stall_valid;
        n_rec_end = r_rec_end;
        w_drive = 1'b0;
        w_aloop = 1'b0;
        w_ref = '0;
        w_q = '0;
        w_cnt = '0;
        w_t = '0;
        w_dead = '0;
        w_at = 1'b0;

        w_mode = (!r_in.fire_gate || r_in.mode_req > MODE_REV) ? MODE_STOP
                 : r_in.mode_req;
        w_single = (w_mode == MODE_SINGLE) || (w_mode == MODE_BURST);
        w_abs_speed = r_in.loader_speed[15] ? 17'(-{r_in.loader_speed[15], r_in.loader_speed})
                      : {1'b0, r_in.loader_speed};
        w_slow = w_abs_speed <= {5'd0, r_stall_tol};

        if (n_recovering && r_in.now_ms >= r_rec_end) begin
            n_recovering = 1'b0;
            n_stall_valid = 1'b0;
        end

        w_at_old = at_tgt(r_target, r_in.loader_angle, w_abs_speed, r_angle_tol,
                          r_settle_tol, r_in.feedback_ok);
        if (!n_recovering && r_in.wheels_on && w_mode != MODE_STOP
            && r_in.feedback_ok) begin
            if (w_slow && ((w_single && r_step_active && !w_at_old) || w_mode == MODE_CONT)) begin
                if (!n_stall_valid) begin
                    n_stall_ms = r_in.now_ms;
                    n_stall_valid = 1'b1;
                end else if ((r_in.now_ms - n_stall_ms) >= {16'd0, r_jam_ms}) begin
                    n_recovering = 1'b1;
                    n_rec_end = r_in.now_ms + {16'd0, r_rec_ms};
                    n_step_active = 1'b0;
                    n_pending = '0;
                    n_target = '0;
                    n_next_ms = '0;
                end
            end else begin
                n_stall_valid = 1'b0;
            end
        end else if (!n_recovering) begin
            n_stall_valid = 1'b0;
        end

        if (!r_in.wheels_on || w_mode == MODE_STOP) begin
            n_step_active = 1'b0;
            n_pending = '0;
            n_target = '0;
            n_next_ms = '0;
            n_recovering = 1'b0;
            n_stall_valid = 1'b0;
        end else if (n_recovering) begin
            w_drive = 1'b1;
            w_ref = RECOVERY_REF;
        end else if (!w_single) begin
            n_step_active = 1'b0;
            n_pending = '0;
            n_target = '0;
            n_next_ms = '0;
            w_drive = 1'b1;
            if (w_mode == MODE_CONT)
                w_ref = (r_in.rate_hz != 16'd0) ? $signed({16'd0, r_in.rate_hz}) * 32'sd540
                        : 32'(r_cont_rpm) * 32'sd384;
            else
                w_ref = (r_in.rate_hz != 16'd0) ? -($signed({16'd0, r_in.rate_hz}) * 32'sd270)
                        : 32'(r_rev_rpm) * 32'sd384;
        end else begin
            if (r_in.request_seq != 16'd0 && r_in.request_seq != r_last_seq) begin
                w_cnt = (w_mode == MODE_SINGLE || r_in.shots_per_burst == 8'd0) ? 8'd1
                        : r_in.shots_per_burst;
                w_q = {1'b0, n_pending} + {1'b0, w_cnt};
                n_last_seq = r_in.request_seq;
                n_pending = (w_q > 9'(SHOT_QUEUE_MAX)) ? 8'(SHOT_QUEUE_MAX) : w_q[7:0];
            end
            if (!n_step_active) begin
                if (n_pending != 8'd0 && r_in.now_ms >= n_next_ms) begin
                    w_t = {r_in.loader_angle[31], r_in.loader_angle} + 33'sd0
                          + $signed({18'd0, r_step_angle});
                    n_target = (w_t > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF : w_t[31:0];
                    n_step_active = 1'b1;
                    w_drive = 1'b1;
                    w_aloop = 1'b1;
                    w_ref = n_target;
                end
            end else begin
                w_drive = 1'b1;
                w_aloop = 1'b1;
                w_ref = n_target;
                w_at = at_tgt(n_target, r_in.loader_angle, w_abs_speed, r_angle_tol,
                              r_settle_tol, r_in.feedback_ok);
                if (w_at) begin
                    n_step_active = 1'b0;
                    if (n_pending != 8'd0) n_pending = n_pending - 8'd1;
                    w_dead = (r_in.rate_hz != 16'd0) ? {13'd0, w_quot}
                             : ((w_mode == MODE_BURST) ? 32'd100 : 32'd125);
                    n_next_ms = r_in.now_ms + w_dead;
                    if (n_pending == 8'd0) begin
                        w_drive = 1'b0;
                        w_aloop = 1'b0;
                        w_ref = '0;
                    end
                end
            end
        end

        n_out.drive_on = w_drive;
        n_out.angle_loop = w_aloop;
        n_out.reference = w_ref;
        n_out.jammed = n_recovering;
        n_out.shown_mode = n_recovering ? MODE_REV
                           : (r_in.wheels_on ? w_mode : MODE_STOP);
        n_out.loader_busy = 1'b0;
        if (w_drive) begin
            if (n_recovering) n_out.loader_busy = 1'b1;
            else if (r_in.wheels_on) begin
                if (w_single)
                    n_out.loader_busy = n_step_active ||
                        (n_pending != 8'd0 && r_in.now_ms >= n_next_ms);
                else
                    n_out.loader_busy = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq <= '0;
            r_pending <= '0;
            r_step_active <= 1'b0;
            r_target <= '0;
            r_next_ms <= '0;
            r_recovering <= 1'b0;
            r_stall_ms <= '0;
            r_stall_valid <= 1'b0;
            r_rec_end <= '0;
        end else if (i_cmd.update) begin
            r_last_seq <= n_last_seq;
            r_pending <= n_pending;
            r_step_active <= n_step_active;
            r_target <= n_target;
            r_next_ms <= n_next_ms;
            r_recovering <= n_recovering;
            r_stall_ms <= n_stall_ms;
            r_stall_valid <= n_stall_valid;
            r_rec_end <= n_rec_end;
        end
        if (i_cmd.load) r_in <= i_in;
        if (i_cmd.update) r_out <= n_out;
    end

    assign o_out = r_out;
endmodule

### hdl/loader_shot_sequencer_jam_recovery.sv
// Top level of the loader shot sequencer with jam recovery.
// One input beat is one control tick: time, gates, mode, shot request,
// rate and loader feedback. Each tick yields exactly one output beat with
// the loader drive command (enable, loop select, reference) and status.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data),
// which the user must write only while no tick is in flight; the block
// does not enforce this. Output valid rises after the divider start, the
// serial divider that forms the dead time ceil(256000/rate), the check
// that sees it finish and the update step that loads the output register.
// The input is ready again in the cycle after the output beat is taken,
// so a new tick is taken only once the last one is through. While the
// receiver stalls the output beat holds and no new input beat is taken.
// Synchronous active-low reset restores the register defaults and clears
// all sequencer state; no output is valid after reset.
module loader_shot_sequencer_jam_recovery (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lssjr_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lssjr_pkg::t_out   o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);
    import lssjr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    lssjr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    lssjr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out      (o_out_data)
    );
endmodule
